/* src/bpiq_pkg.sv */
`default_nettype none

package bpiq_pkg;

    // Fixed sizes of the front panel.
    localparam int NUM_BUTTONS = 5;
    localparam int NUM_POTS    = 3;
    localparam int HIGH_BUTTON = 4;

    localparam int ADC_W   = 10;
    localparam int LEVEL_W = 8;
    localparam int LOCK_W  = 16;
    localparam int IVAL_W  = 16;
    localparam int SENS_W  = 8;
    localparam int DUR_W   = 24;
    localparam int ZONE_W  = 2;

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = DUR_W;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_BUTTON_LOCKOUT       = 2'd0,
        CFG_POT_INTERVAL         = 2'd1,
        CFG_POT_SENSITIVITY      = 2'd2,
        CFG_INTERACTIVE_DURATION = 2'd3
    } t_cfg_idx;

    localparam logic [LOCK_W-1:0] RST_LOCKOUT  = 16'd250;
    localparam logic [IVAL_W-1:0] RST_INTERVAL = 16'd50;
    localparam logic [SENS_W-1:0] RST_SENS     = 8'd5;
    localparam logic [DUR_W-1:0]  RST_DURATION = 24'd60000;

    // Input tdata layout, lowest bit first.
    localparam int IN_BTN_LSB   = 0;
    localparam int IN_POT_LSB   = IN_BTN_LSB + NUM_BUTTONS;
    localparam int IN_ZONE_LSB  = IN_POT_LSB + NUM_POTS * ADC_W;
    localparam int IN_BACK_LSB  = IN_ZONE_LSB + ZONE_W;
    localparam int IN_PACK_LSB  = IN_BACK_LSB + NUM_BUTTONS;
    localparam int IN_USED_W    = IN_PACK_LSB + NUM_POTS;
    localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

    // Output tdata layout, lowest bit first.
    localparam int OUT_BPEND_LSB = 0;
    localparam int OUT_LVL_LSB   = OUT_BPEND_LSB + NUM_BUTTONS;
    localparam int OUT_PPEND_LSB = OUT_LVL_LSB + NUM_POTS * LEVEL_W;
    localparam int OUT_INTER_BIT = OUT_PPEND_LSB + NUM_POTS;
    localparam int OUT_UNH_BIT   = OUT_INTER_BIT + 1;
    localparam int OUT_ZONE_LSB  = OUT_UNH_BIT + 1;
    localparam int OUT_USED_W    = OUT_ZONE_LSB + ZONE_W;
    localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

    // Scale a converter sample as raw*255/1023 with adders only:
    // raw*255 is (raw<<8)-raw, and p/1023 is (p + (p>>10) + 1) >> 10
    // for every product that fits in 18 bits.
    function automatic logic [LEVEL_W-1:0] scale_level(input logic [ADC_W-1:0] raw);
        logic [17:0] prod;
        logic [17:0] sum;
        prod = {raw, 8'b0} - {8'b0, raw};
        sum  = prod + {10'b0, prod[17:10]} + 18'd1;
        return sum[17:10];
    endfunction

endpackage

`default_nettype wire

/* src/button_pot_input_qualifier_top.sv */
// Channel   | Direction | Payload (lowest bit first)
// s_axis    | in        | button_raw, pot_sample_a/b/c, zone_raw, button_ack, pot_ack
// m_axis    | out       | button_pending, pot_level_a/b/c, pot_pending, interactive,
//           |           | unhandled_any, zone
// cfg       | in        | write enable, register index, write data
//
// Each accepted tick item has its result in the output register on the next
// cycle, and a new item may follow in every cycle while the input is not stalled.
// A single output register decouples the sides: the input stalls only while
// that register is full and the downstream side is not ready.
// Reset is synchronous and active low; it restores all registers and state but the output data register.
`default_nettype none

module button_pot_input_qualifier_top (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  s_axis_tvalid,
    output      logic                                  s_axis_tready,
    // button_raw[4:0], pot_sample_a[14:5], pot_sample_b[24:15], pot_sample_c[34:25],
    // zone_raw[36:35], button_ack[41:37], pot_ack[44:42], zero pad
    input  wire logic [bpiq_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    output      logic                                  m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // button_pending[4:0], pot_level_a[12:5], pot_level_b[20:13], pot_level_c[28:21],
    // pot_pending[31:29], interactive[32], unhandled_any[33], zone[35:34], zero pad
    output      logic [bpiq_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    input  wire logic                                  i_cfg_we,
    input  wire logic [bpiq_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  wire logic [bpiq_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);
    import bpiq_pkg::*;

    // Configuration registers.
    logic [LOCK_W-1:0] r_cfg_lockout;
    logic [IVAL_W-1:0] r_cfg_interval;
    logic [SENS_W-1:0] r_cfg_sens;
    logic [DUR_W-1:0]  r_cfg_duration;

    // Qualifier state and its next values.
    logic [NUM_BUTTONS-1:0]  r_btn_active,  n_btn_active;
    logic [NUM_BUTTONS-1:0]  r_btn_handled, n_btn_handled;
    logic [LOCK_W-1:0]       r_btn_timer [NUM_BUTTONS];
    logic [LOCK_W-1:0]       n_btn_timer [NUM_BUTTONS];
    logic [LEVEL_W-1:0]      r_pot_level [NUM_POTS];
    logic [LEVEL_W-1:0]      n_pot_level [NUM_POTS];
    logic [NUM_POTS-1:0]     r_pot_handled, n_pot_handled;
    logic [IVAL_W-1:0]       r_pot_timer,   n_pot_timer;
    logic                    r_pots_loaded, n_pots_loaded;
    logic                    r_inter_active, n_inter_active;
    logic [DUR_W-1:0]        r_inter_timer, n_inter_timer;

    // Output register.
    logic                    r_out_valid;
    logic [OUT_TDATA_W-1:0]  r_out_data, n_out_data;

    // Unpacked input fields.
    logic [NUM_BUTTONS-1:0]  in_button_raw;
    logic [NUM_BUTTONS-1:0]  in_button_ack;
    logic [NUM_POTS-1:0]     in_pot_ack;
    logic [ZONE_W-1:0]       in_zone_raw;
    logic [ADC_W-1:0]        in_sample [NUM_POTS];

    logic                    in_xfer;
    logic                    out_xfer;
    logic                    btn_press;
    logic                    open_win;
    logic [LEVEL_W-1:0]      samp_level;
    logic [LEVEL_W:0]        up_bound;
    logic [LEVEL_W:0]        down_sum;

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = r_out_valid && m_axis_tready;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign in_button_raw = s_axis_tdata[IN_BTN_LSB +: NUM_BUTTONS];
    assign in_zone_raw   = s_axis_tdata[IN_ZONE_LSB +: ZONE_W];
    assign in_button_ack = s_axis_tdata[IN_BACK_LSB +: NUM_BUTTONS];
    assign in_pot_ack    = s_axis_tdata[IN_PACK_LSB +: NUM_POTS];

    always_comb begin
        for (int p = 0; p < NUM_POTS; p++) begin
            in_sample[p] = s_axis_tdata[IN_POT_LSB + p*ADC_W +: ADC_W];
        end
    end

    // One tick of qualification: acks, window countdown, buttons, pots.
    always_comb begin
        n_btn_handled  = r_btn_handled | in_button_ack;
        n_pot_handled  = r_pot_handled | in_pot_ack;
        n_btn_active   = r_btn_active;
        n_btn_timer    = r_btn_timer;
        n_pot_level    = r_pot_level;
        n_pot_timer    = r_pot_timer;
        n_pots_loaded  = r_pots_loaded;
        n_inter_active = r_inter_active;
        n_inter_timer  = r_inter_timer;
        open_win       = 1'b0;
        btn_press      = 1'b0;
        samp_level     = '0;
        up_bound       = '0;
        down_sum       = '0;

        // The window closes one tick after its counter reaches zero.
        if (r_inter_active) begin
            if (r_inter_timer == '0) begin
                n_inter_active = 1'b0;
            end else begin
                n_inter_timer = r_inter_timer - 1'b1;
            end
        end

        // Lockout per button; a held button is pressed again each time its lockout expires.
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            btn_press = (b == HIGH_BUTTON) ? in_button_raw[b] : !in_button_raw[b];
            if (r_btn_active[b]) begin
                if (r_btn_timer[b] == '0) begin
                    n_btn_active[b]  = 1'b0;
                    n_btn_handled[b] = 1'b1;
                end else begin
                    n_btn_timer[b] = r_btn_timer[b] - 1'b1;
                end
            end
            if (!n_btn_active[b] && btn_press) begin
                open_win         = 1'b1;
                n_btn_active[b]  = 1'b1;
                n_btn_handled[b] = 1'b0;
                n_btn_timer[b]   = r_cfg_lockout;
            end
        end

        // Pot sampling: the first tick loads silently, later ones use the deadband when the interval timer is zero.
        if (!r_pots_loaded) begin
            n_pots_loaded = 1'b1;
            n_pot_timer   = r_cfg_interval;
            for (int p = 0; p < NUM_POTS; p++) begin
                n_pot_level[p] = scale_level(in_sample[p]);
            end
        end else if (r_pot_timer == '0) begin
            n_pot_timer = r_cfg_interval;
            for (int p = 0; p < NUM_POTS; p++) begin
                samp_level = scale_level(in_sample[p]);
                up_bound   = {1'b0, r_pot_level[p]} + {1'b0, r_cfg_sens};
                down_sum   = {1'b0, samp_level} + {1'b0, r_cfg_sens};
                if (({1'b0, samp_level} >= up_bound) ||
                    (down_sum <= {1'b0, r_pot_level[p]})) begin
                    open_win         = 1'b1;
                    n_pot_level[p]   = samp_level;
                    n_pot_handled[p] = 1'b0;
                end
            end
        end else begin
            n_pot_timer = r_pot_timer - 1'b1;
        end

        // Activity opens or refreshes the interactive window.
        if (open_win) begin
            n_inter_active = 1'b1;
            n_inter_timer  = r_cfg_duration;
        end
    end

    // Result packing.
    always_comb begin
        n_out_data = '0;
        n_out_data[OUT_BPEND_LSB +: NUM_BUTTONS] = n_btn_active & ~n_btn_handled;
        for (int p = 0; p < NUM_POTS; p++) begin
            n_out_data[OUT_LVL_LSB + p*LEVEL_W +: LEVEL_W] = n_pot_level[p];
        end
        n_out_data[OUT_PPEND_LSB +: NUM_POTS] = ~n_pot_handled;
        n_out_data[OUT_INTER_BIT] = n_inter_active;
        n_out_data[OUT_UNH_BIT]   = n_inter_active &&
                                    ((|(~n_btn_handled)) || (|(~n_pot_handled)));
        n_out_data[OUT_ZONE_LSB +: ZONE_W] = ~in_zone_raw;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_lockout  <= RST_LOCKOUT;
            r_cfg_interval <= RST_INTERVAL;
            r_cfg_sens     <= RST_SENS;
            r_cfg_duration <= RST_DURATION;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_BUTTON_LOCKOUT:       r_cfg_lockout  <= i_cfg_wdata[LOCK_W-1:0];
                CFG_POT_INTERVAL:         r_cfg_interval <= i_cfg_wdata[IVAL_W-1:0];
                CFG_POT_SENSITIVITY:      r_cfg_sens     <= i_cfg_wdata[SENS_W-1:0];
                CFG_INTERACTIVE_DURATION: r_cfg_duration <= i_cfg_wdata[DUR_W-1:0];
            endcase
        end
    end

    // State advances on every accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_btn_active   <= '0;
            r_btn_handled  <= '1;
            r_pot_handled  <= '1;
            r_pot_timer    <= '0;
            r_pots_loaded  <= 1'b0;
            r_inter_active <= 1'b0;
            r_inter_timer  <= '0;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_btn_timer[b] <= '0;
            end
            for (int p = 0; p < NUM_POTS; p++) begin
                r_pot_level[p] <= '0;
            end
        end else if (in_xfer) begin
            r_btn_active   <= n_btn_active;
            r_btn_handled  <= n_btn_handled;
            r_btn_timer    <= n_btn_timer;
            r_pot_level    <= n_pot_level;
            r_pot_handled  <= n_pot_handled;
            r_pot_timer    <= n_pot_timer;
            r_pots_loaded  <= n_pots_loaded;
            r_inter_active <= n_inter_active;
            r_inter_timer  <= n_inter_timer;
        end
    end

    // Output register: loads on an input transfer, empties on an output transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

`default_nettype wire

/* src/bpiq_checker.sv */
`default_nettype none

module bpiq_checker (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 s_axis_tvalid,
    input wire logic                                 s_axis_tready,
    input wire logic [bpiq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input wire logic                                 m_axis_tvalid,
    input wire logic                                 m_axis_tready,
    input wire logic [bpiq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import bpiq_pkg::*;

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // An empty result register never stalls the input side.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // Each accepted tick yields a result in the next cycle with the decoded zone.
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=>
            (m_axis_tvalid && (m_axis_tdata[OUT_ZONE_LSB +: ZONE_W] ==
                               ~$past(s_axis_tdata[IN_ZONE_LSB +: ZONE_W]))))
        else $error("missing result or wrong zone");

    // The unhandled flag only shows inside the interactive window.
    a_unhandled_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[OUT_UNH_BIT] || m_axis_tdata[OUT_INTER_BIT]))
        else $error("unhandled flag outside interactive window");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind button_pot_input_qualifier_top bpiq_checker u_bpiq_checker (.*);

`default_nettype wire
